// File: hdl/frbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the free-run bitmap search block.
// No dependencies; imported by every module of the block but frbs_ram.
package frbs_pkg;

    localparam int DEF_MAP_DEPTH = 1024;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;
    localparam int POS_W         = 32;
    localparam int MIN_W         = 11;
    localparam int NUM_W         = 11;
    localparam int S_TDATA_W     = 48;
    localparam int CFG_IDX_W     = 1;

    localparam logic [NUM_W-1:0] RESET_NUM_CHOICES = 11'd1024;

    localparam logic FUNC_MARK = 1'b0;
    localparam logic FUNC_FIND = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_CHOICE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHOICES = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_MARK,
        ST_SCAN,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic check;
        logic mark_write;
        logic scan_step;
        logic clear_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_find;
        logic in_range;
        logic hit;
        logic last_word;
        logic clear_done;
        logic out_free;
    } dp_sts_t;

endpackage

// File: hdl/frbs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frbs_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/frbs_ctrl.sv
`timescale 1ns / 1ps
// Control state machine: clearing pass, item decode, mark, scan and result hand-off.
// Depends on frbs_pkg.
module frbs_ctrl
    import frbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.in_range)
                begin
                    state_next = sts.is_find ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    state_next = sts.is_find ? ST_SCAN : ST_MARK;
                end
            end
            ST_MARK:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sts.hit || sts.last_word)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ST_MARK:
            begin
                cmd.mark_write = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/frbs_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, item registers, bitmap RAM, word-wide run scanner, output register.
// Depends on frbs_pkg and frbs_ram.
module frbs_dp
    import frbs_pkg::*;
#(
    parameter int MAP_DEPTH = DEF_MAP_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  logic [0:0]           in_user,
    input  logic [S_TDATA_W-1:0] in_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_W-1:0]     out_data,
    output logic [0:0]           out_user
);

    localparam int WORDS = (MAP_DEPTH + WORD_W - 1) / WORD_W;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IX_W  = WA_W + BIT_W;
    localparam int LIM_W = IX_W + 1;
    localparam int LEN_W = BIT_W + 1;
    localparam int CMP_W = (LIM_W > MIN_W) ? LIM_W : MIN_W;

    // configuration
    logic [POS_W-1:0] base_reg;
    logic [NUM_W-1:0] num_reg;
    logic [LIM_W-1:0] limit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            num_reg  <= RESET_NUM_CHOICES;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE_CHOICE: base_reg <= cfg_data;
                REG_NUM_CHOICES: num_reg  <= cfg_data[NUM_W-1:0];
                default:         base_reg <= base_reg;
            endcase
        end
    end

    always_comb
    begin
        if (POS_W'(num_reg) > POS_W'(MAP_DEPTH))
        begin
            limit = LIM_W'(MAP_DEPTH);
        end
        else
        begin
            limit = LIM_W'(num_reg);
        end
    end

    // item registers
    logic             is_find_reg;
    logic             in_range_reg;
    logic [IX_W-1:0]  idx_reg;
    logic [MIN_W-1:0] min_reg;
    logic [POS_W-1:0] offset;

    assign offset = in_data[POS_W-1:0] - base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_find_reg  <= 1'b0;
            in_range_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            is_find_reg  <= (in_user[0] == FUNC_FIND);
            in_range_reg <= (offset < POS_W'(limit));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= offset[IX_W-1:0];
            min_reg <= in_data[POS_W +: MIN_W];
        end
    end

    // bitmap RAM and clearing pass
    logic [WA_W-1:0]   clr_addr_reg;
    logic [WA_W-1:0]   clr_addr_next;
    logic [WA_W-1:0]   scan_word_reg;
    logic [WA_W-1:0]   scan_word_next;
    logic              ram_we;
    logic [WA_W-1:0]   ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WA_W-1:0]   ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clear_step)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        ram_we    = cmd.clear_step || cmd.mark_write;
        ram_waddr = cmd.clear_step ? clr_addr_reg : idx_reg[IX_W-1:BIT_W];
        ram_wdata = cmd.clear_step ? '0
                                   : (ram_rdata | (WORD_W'(1) << idx_reg[BIT_W-1:0]));
        ram_raddr = cmd.check ? idx_reg[IX_W-1:BIT_W] : scan_word_reg + 1'b1;
    end

    frbs_ram
    #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    )
    u_map
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // word scanner: run lengths by doubling, then first run reaching the wanted length
    logic [WORD_W-1:0] bits_w;
    logic [LEN_W-1:0]  lv [BIT_W+1][WORD_W];
    logic [WORD_W-1:0] full_w;
    logic [LIM_W-1:0]  tot [WORD_W];
    logic [WORD_W-1:0] hit_w;
    logic [IX_W-1:0]   st [WORD_W];
    logic [IX_W-1:0]   bit_ix [WORD_W];
    logic [MIN_W-1:0]  min_eff;
    logic              hit;
    logic [IX_W-1:0]   hit_start;

    logic [LIM_W-1:0]  carry_reg;
    logic [LIM_W-1:0]  carry_next;
    logic [IX_W-1:0]   carry_start_reg;
    logic [IX_W-1:0]   carry_start_next;
    logic              res_found_reg;
    logic              res_found_next;
    logic [IX_W-1:0]   res_idx_reg;
    logic [IX_W-1:0]   res_idx_next;

    assign min_eff = (min_reg == '0) ? MIN_W'(1) : min_reg;

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            bit_ix[j] = {scan_word_reg, BIT_W'(j)};
            bits_w[j] = ram_rdata[j] && (bit_ix[j] >= idx_reg)
                        && (LIM_W'(bit_ix[j]) < limit);
            lv[0][j]  = LEN_W'(bits_w[j]);
        end
        for (int s = 0; s < BIT_W; s++)
        begin
            for (int j = 0; j < WORD_W; j++)
            begin
                if ((j >= (1 << s)) && (lv[s][j] == LEN_W'(1 << s)))
                begin
                    lv[s+1][j] = LEN_W'(1 << s) + lv[s][(j >= (1 << s)) ? j - (1 << s) : 0];
                end
                else
                begin
                    lv[s+1][j] = lv[s][j];
                end
            end
        end
        for (int j = 0; j < WORD_W; j++)
        begin
            full_w[j] = (lv[BIT_W][j] == LEN_W'(j + 1));
            tot[j]    = LIM_W'(lv[BIT_W][j]) + (full_w[j] ? carry_reg : '0);
            hit_w[j]  = (CMP_W'(tot[j]) >= CMP_W'(min_eff));
            if (full_w[j] && (carry_reg != '0))
            begin
                st[j] = carry_start_reg;
            end
            else
            begin
                st[j] = {scan_word_reg, BIT_W'(LEN_W'(j + 1) - lv[BIT_W][j])};
            end
        end
        hit       = 1'b0;
        hit_start = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (hit_w[j])
            begin
                hit       = 1'b1;
                hit_start = st[j];
            end
        end
    end

    always_comb
    begin
        scan_word_next   = scan_word_reg;
        carry_next       = carry_reg;
        carry_start_next = carry_start_reg;
        res_found_next   = res_found_reg;
        res_idx_next     = res_idx_reg;
        if (cmd.check)
        begin
            scan_word_next   = idx_reg[IX_W-1:BIT_W];
            carry_next       = '0;
            carry_start_next = '0;
            res_found_next   = 1'b0;
            res_idx_next     = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_word_next   = scan_word_reg + 1'b1;
            carry_next       = tot[WORD_W-1];
            carry_start_next = st[WORD_W-1];
            if (hit)
            begin
                res_found_next = 1'b1;
                res_idx_next   = hit_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_found_reg <= 1'b0;
        end
        else
        begin
            res_found_reg <= res_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_word_reg   <= scan_word_next;
        carry_reg       <= carry_next;
        carry_start_reg <= carry_start_next;
        res_idx_reg     <= res_idx_next;
    end

    // output register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [POS_W-1:0] out_data_reg;
    logic [0:0]       out_user_reg;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= res_found_reg ? (base_reg + POS_W'(res_idx_reg)) : '0;
            out_user_reg <= res_found_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    // status to controller
    always_comb
    begin
        sts.is_find    = is_find_reg;
        sts.in_range   = in_range_reg;
        sts.hit        = hit;
        sts.last_word  = ((LIM_W + 1)'({scan_word_reg, BIT_W'(0)}) + (LIM_W + 1)'(WORD_W))
                         >= (LIM_W + 1)'(limit);
        sts.clear_done = (clr_addr_reg == WA_W'(WORDS - 1));
        sts.out_free   = out_free;
    end

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_write |-> (in_range_reg && !is_find_reg))
        else $error("mark write without an in-range mark item");

    a_scan_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (LIM_W'({scan_word_reg, BIT_W'(0)}) < limit))
        else $error("scan past the last word in use");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && res_found_reg) |-> (LIM_W'(res_idx_reg) < limit))
        else $error("found run start outside the map in use");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over a pending word");

endmodule

// File: hdl/free_run_bitmap_search_top.sv
`timescale 1ns / 1ps
// Top level of the free-run bitmap search block: controller plus datapath.
// Depends on frbs_pkg, frbs_ctrl, frbs_dp (and frbs_ram below it).
//
// Usage:
//   s_axis carries one word per item: tuser = func (mark free / find),
//   tdata = position, want_len. A mark sets one map bit if in range and gives no result;
//   a find gives one m_axis word: tuser = found, tdata = run_start.
//   cfg carries register writes (index 0 base_choice, 1 num_choices); write
//   only while no item is in flight. cfg_ready is always high.
// Sequence:
//   A mark reads its map word and writes it back with the bit set before the next word is taken.
//   A find reads its start word, then scans W 32-bit map words, one RAM read per cycle,
//   W being 0 for a start out of range, else 1 up to 32 for 1024 choices; it then
//   loads the output register, and the next word is taken once that is done.
//   One item is in work at a time; s_axis_tready is high only between items.
// Reset:
//   After rst_n releases, a clearing pass zeroes every map word, ceil(MAP_DEPTH/32)
//   of them (32 by default); no item is taken meanwhile.
// Stall:
//   A result waits in the output register; marks go on while it waits, and
//   the next find holds before output until the register is taken.
module free_run_bitmap_search_top
    import frbs_pkg::*;
#(
    parameter int MAP_DEPTH = DEF_MAP_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // position[31:0], want_len[42:32], zero pad
    input  logic [0:0]           s_axis_tuser,  // func[0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [POS_W-1:0]     m_axis_tdata,  // run_start[31:0]
    output logic [0:0]           m_axis_tuser,  // found[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    frbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    frbs_dp
    #(
        .MAP_DEPTH (MAP_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_user   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for free_run_bitmap_search_top: stream driver, monitor,
// and a bit-level predictor of the free map. Depends on frbs_pkg and the RTL.
module testbench;
    import frbs_pkg::*;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] position;
        logic [MIN_W-1:0] want_len;
    } bm_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] run_start;
    } bm_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [POS_W-1:0]     m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0]     cfg_data = '0;

    bm_item_t   pending_words[$];
    bm_result_t expected_runs[$];
    bm_item_t   cur_word;

    bit               free_bits [DEF_MAP_DEPTH];
    logic [POS_W-1:0] cur_base = '0;
    logic [NUM_W-1:0] cur_num = RESET_NUM_CHOICES;

    bit idle_en = 1'b1;
    int s_gap = 0;
    int m_gap = 0;
    int errors = 0;
    int n_marks = 0;
    int n_finds = 0;
    int n_hits = 0;
    int n_settings = 0;

    free_run_bitmap_search_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned active_span();
        if (cur_num > DEF_MAP_DEPTH)
            return DEF_MAP_DEPTH;
        return 32'(cur_num);
    endfunction

    function automatic void mark_free(logic [POS_W-1:0] pos);
        logic [POS_W-1:0] ofs;
        ofs = pos - cur_base;
        if (ofs < active_span())
            free_bits[ofs] = 1'b1;
    endfunction

    // first-fit, walking runs of equal bits; no wrap past the last choice
    function automatic bm_result_t search_run(logic [POS_W-1:0] start, logic [MIN_W-1:0] want);
        bm_result_t  r;
        int unsigned lim;
        int unsigned i;
        int unsigned j;
        logic [POS_W-1:0] ofs;
        r = '0;
        lim = active_span();
        ofs = start - cur_base;
        if (ofs >= lim)
            return r;
        i = ofs;
        while (i < lim)
        begin
            j = i;
            while (j < lim && free_bits[j] == free_bits[i])
                j++;
            if (free_bits[i] && (j - i) >= want)
            begin
                r.found = 1'b1;
                r.run_start = cur_base + i;
                return r;
            end
            i = j;
        end
        return r;
    endfunction

    function automatic logic [MIN_W-1:0] pick_min(int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return MIN_W'($urandom_range(0, 4));
        if (r < 80)
            return MIN_W'($urandom_range(5, 40));
        if (r < 95)
            return MIN_W'($urandom_range(0, 1024));
        if (r < 98)
            return MIN_W'(lim);
        return 11'd1024;
    endfunction

    task automatic add_word(logic f, logic [POS_W-1:0] p, logic [MIN_W-1:0] m);
        bm_item_t w;
        w.func = f;
        w.position = p;
        w.want_len = m;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_BASE_CHOICE)
            cur_base = val;
        else
            cur_num = val[NUM_W-1:0];
    endtask

    task automatic set_config(logic [POS_W-1:0] base, logic [NUM_W-1:0] num);
        write_reg(REG_BASE_CHOICE, base);
        write_reg(REG_NUM_CHOICES, {{(POS_W-NUM_W){1'b0}}, num});
        n_settings++;
    endtask

    // nothing queued, nothing on the bus, nothing outstanding; then let a mark drain
    task automatic settle();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_runs.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic fill_random(int n);
        int k;
        int r;
        int len;
        int unsigned lim;
        logic [POS_W-1:0] p;
        lim = active_span();
        k = 0;
        while (k < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 35 && lim > 0)
            begin
                add_word(FUNC_MARK, cur_base + $urandom_range(0, lim - 1),
                         MIN_W'($urandom_range(0, 1024)));
                k++;
            end
            else if (r < 45 && lim > 0)
            begin
                p = cur_base + $urandom_range(0, lim - 1);
                len = $urandom_range(2, 12);
                repeat (len)
                begin
                    add_word(FUNC_MARK, p, MIN_W'($urandom_range(0, 1024)));
                    p++;
                end
                k += len;
            end
            else if (r < 52)
            begin
                p = $urandom_range(0, 1) ? $urandom : cur_base + lim + $urandom_range(0, 3);
                add_word(FUNC_MARK, p, MIN_W'($urandom_range(0, 1024)));
                k++;
            end
            else if (r < 90 && lim > 0)
            begin
                add_word(FUNC_FIND, cur_base + $urandom_range(0, lim - 1), pick_min(lim));
                k++;
            end
            else
            begin
                p = $urandom_range(0, 1) ? $urandom : cur_base + lim + $urandom_range(0, 3);
                add_word(FUNC_FIND, p, pick_min(lim));
                k++;
            end
        end
    endtask

    // stream driver; prediction happens on acceptance
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (s_axis_tvalid)
            begin
                if (cur_word.func == FUNC_MARK)
                begin
                    mark_free(cur_word.position);
                    n_marks++;
                end
                else
                begin
                    expected_runs.push_back(search_run(cur_word.position, cur_word.want_len));
                    n_finds++;
                end
            end
            if (s_gap > 0)
            begin
                s_gap <= s_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (idle_en && pending_words.size() != 0 && $urandom_range(0, 5) == 0)
            begin
                s_gap <= $urandom_range(0, 10);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                cur_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(S_TDATA_W-POS_W-MIN_W){1'b0}},
                                  cur_word.want_len, cur_word.position};
                s_axis_tuser  <= cur_word.func;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor and backpressure
    always @(posedge clk)
    begin
        bm_result_t exp_r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("unexpected result word: found %0d run_start %h",
                           m_axis_tuser[0], m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = expected_runs.pop_front();
                    if (m_axis_tuser[0] !== exp_r.found)
                    begin
                        $error("found: expected %0d, got %0d", exp_r.found, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tdata !== exp_r.run_start)
                    begin
                        $error("run_start: expected %h, got %h", exp_r.run_start, m_axis_tdata);
                        errors++;
                    end
                    if (exp_r.found)
                        n_hits++;
                end
            end
            if (m_gap > 0)
            begin
                m_gap <= m_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                m_gap <= $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #4_000_000;
        $display("timeout: %0d result words still outstanding", expected_runs.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [POS_W-1:0] base;
        logic [NUM_W-1:0] num;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty map, edges of the range, runs at the end, mid-run start
        add_word(FUNC_FIND, 32'd0, 11'd0);
        add_word(FUNC_MARK, 32'd0, 11'd0);
        add_word(FUNC_MARK, 32'd1023, 11'd1024);
        add_word(FUNC_MARK, 32'd1024, 11'd0);
        add_word(FUNC_MARK, 32'hFFFF_FFFF, 11'd0);
        add_word(FUNC_FIND, 32'd0, 11'd0);
        add_word(FUNC_FIND, 32'd1, 11'd1);
        add_word(FUNC_FIND, 32'd1, 11'd2);
        add_word(FUNC_FIND, 32'd1024, 11'd0);
        add_word(FUNC_FIND, 32'hFFFF_FFFF, 11'd0);
        for (int i = 5; i < 10; i++)
            add_word(FUNC_MARK, i, 11'd0);
        add_word(FUNC_FIND, 32'd2, 11'd5);
        add_word(FUNC_FIND, 32'd2, 11'd6);
        add_word(FUNC_FIND, 32'd7, 11'd3);
        add_word(FUNC_FIND, 32'd0, 11'd1024);
        settle();

        // tiny map fully free: run that fills the whole span
        set_config(32'd0, 11'd4);
        add_word(FUNC_MARK, 32'd1, 11'd0);
        add_word(FUNC_MARK, 32'd2, 11'd0);
        add_word(FUNC_MARK, 32'd3, 11'd0);
        add_word(FUNC_FIND, 32'd0, 11'd4);
        add_word(FUNC_FIND, 32'd0, 11'd5);
        add_word(FUNC_FIND, 32'd3, 11'd1);
        settle();

        for (int p = 0; p < 12; p++)
        begin
            n = 55;
            case (p)
                0: begin base = 32'hFFFF_FFF0; num = 11'd1024; end
                1: begin base = 32'hFFFF_FFFF; num = 11'd1;    end
                2: begin base = 32'd0;         num = 11'd0;    n = 10; end
                3: begin base = $urandom;      num = 11'd2047; end
                4: begin base = 32'h8000_0000; num = 11'd33;   end
                5: begin base = 32'd0;         num = 11'd32;   end
                default:
                begin
                    base = $urandom_range(0, 1) ? 32'd0 : $urandom;
                    num = ($urandom_range(0, 3) == 0) ? 11'd1024
                                                      : NUM_W'($urandom_range(1, 1024));
                end
            endcase
            idle_en = (p < 10);
            set_config(base, num);
            fill_random(n);
            settle();
        end

        $display("covered %0d mark and %0d find words, %0d finds hit a run,",
                 n_marks, n_finds, n_hits);
        $display("across %0d register settings including wrapped bases and span extremes",
                 n_settings);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
